// ----- hw/rtl/ipte_pkg.sv -----
// Shared constants and controller-to-datapath command type for the IPv6 text expander.
`timescale 1ns / 1ps

package ipte_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;

    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic commit;    // store the group that the final character closed
        logic load_out;  // load the output register with the selected character
        logic out_last;  // the loaded character ends the expanded text
        logic clear;     // return the address state to its reset values
    } ipte_cmd_t;

endpackage

// ----- hw/rtl/ipte_dp.sv -----
// Datapath of the IPv6 text expander: group assembly, group store and output register.
`timescale 1ns / 1ps

module ipte_dp #(
    parameter int MAX_GROUPS       = 8,
    parameter int DIGITS_PER_GROUP = 4,
    parameter int CW               = $clog2(MAX_GROUPS + 1),
    parameter int DW               = $clog2(DIGITS_PER_GROUP + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ipte_pkg::ipte_cmd_t cmd,
    input  logic [7:0]          char_in,
    input  logic [CW-1:0]       slot,
    input  logic [DW-1:0]       pos,
    output logic                gap_seen,
    output logic [CW-1:0]       group_count,
    output logic [7:0]          char_out,
    output logic                last_char
);
    import ipte_pkg::*;

    localparam int IW = $clog2(MAX_GROUPS);
    localparam int PW = (DIGITS_PER_GROUP > 1) ? $clog2(DIGITS_PER_GROUP) : 1;
    localparam logic [CW:0] MG_X = (CW + 1)'(MAX_GROUPS);
    localparam logic [DW-1:0] D_X = DW'(DIGITS_PER_GROUP);

    // The partial group is kept right-aligned: new digits enter at the end and
    // older ones move toward the front, so unused leading places stay '0'.
    logic [7:0]    partial_reg [DIGITS_PER_GROUP];
    logic [7:0]    partial_next [DIGITS_PER_GROUP];
    logic [DW-1:0] digit_cnt_reg, digit_cnt_next;
    logic [CW-1:0] group_cnt_reg, group_cnt_next;
    logic          gap_reg, gap_next;
    logic [CW-1:0] gap_pos_reg, gap_pos_next;
    logic          prev_colon_reg, prev_colon_next;
    logic          store_we;

    logic [7:0]    store_reg [MAX_GROUPS][DIGITS_PER_GROUP];
    logic [7:0]    data_reg;
    logic          last_reg;

    logic          is_colon;
    logic [CW:0]   slot_x, gc_x, zeros_end;
    logic [CW:0]   idx_full;
    logic          zero_fill, after_gap;
    logic [DW-1:0] pos_m1;

    assign is_colon = (char_in == COLON_CHAR);

    always_comb
    begin
        partial_next    = partial_reg;
        digit_cnt_next  = digit_cnt_reg;
        group_cnt_next  = group_cnt_reg;
        gap_next        = gap_reg;
        gap_pos_next    = gap_pos_reg;
        prev_colon_next = prev_colon_reg;
        store_we        = 1'b0;

        if (cmd.accept)
        begin
            if (is_colon)
            begin
                if (prev_colon_reg)
                begin
                    if (!gap_reg)
                    begin
                        gap_next     = 1'b1;
                        gap_pos_next = group_cnt_reg;
                    end
                    prev_colon_next = 1'b0;
                end
                else
                begin
                    store_we        = 1'b1;
                    prev_colon_next = 1'b1;
                end
            end
            else
            begin
                if (digit_cnt_reg < D_X)
                begin
                    for (int k = 0; k < DIGITS_PER_GROUP - 1; k++)
                        partial_next[k] = partial_reg[k + 1];
                    partial_next[DIGITS_PER_GROUP - 1] = char_in;
                    digit_cnt_next = digit_cnt_reg + 1'b1;
                end
                prev_colon_next = 1'b0;
            end
        end

        if (cmd.commit)
            store_we = 1'b1;

        if (store_we)
        begin
            if (group_cnt_reg < CW'(MAX_GROUPS))
                group_cnt_next = group_cnt_reg + 1'b1;
            for (int k = 0; k < DIGITS_PER_GROUP; k++)
                partial_next[k] = ZERO_CHAR;
            digit_cnt_next = '0;
        end

        if (cmd.clear)
        begin
            group_cnt_next  = '0;
            gap_next        = 1'b0;
            gap_pos_next    = '0;
            prev_colon_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIGITS_PER_GROUP; k++)
                partial_reg[k] <= ZERO_CHAR;
            digit_cnt_reg  <= '0;
            group_cnt_reg  <= '0;
            gap_reg        <= 1'b0;
            gap_pos_reg    <= '0;
            prev_colon_reg <= 1'b0;
        end
        else
        begin
            partial_reg    <= partial_next;
            digit_cnt_reg  <= digit_cnt_next;
            group_cnt_reg  <= group_cnt_next;
            gap_reg        <= gap_next;
            gap_pos_reg    <= gap_pos_next;
            prev_colon_reg <= prev_colon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we && (group_cnt_reg < CW'(MAX_GROUPS)))
            store_reg[group_cnt_reg[IW-1:0]] <= partial_reg;
    end

    // Map an output slot to a stored group or to an inserted zero group.
    always_comb
    begin
        slot_x    = (CW + 1)'(slot);
        gc_x      = (CW + 1)'(group_cnt_reg);
        zeros_end = (CW + 1)'(gap_pos_reg) + MG_X - gc_x;
        zero_fill = gap_reg && (slot >= gap_pos_reg) && (slot_x < zeros_end);
        after_gap = gap_reg && (slot_x >= zeros_end);
        idx_full  = after_gap ? (slot_x - (MG_X - gc_x)) : slot_x;
        pos_m1    = pos - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (pos == '0)
                data_reg <= COLON_CHAR;
            else if (zero_fill)
                data_reg <= ZERO_CHAR;
            else
                data_reg <= store_reg[idx_full[IW-1:0]][pos_m1[PW-1:0]];
            last_reg <= cmd.out_last;
        end
    end

    assign gap_seen    = gap_reg;
    assign group_count = group_cnt_reg;
    assign char_out    = data_reg;
    assign last_char   = last_reg;

endmodule

// ----- hw/rtl/ipte_ctrl.sv -----
// Controller of the IPv6 text expander: collect, finish and emit sequencing.
`timescale 1ns / 1ps

module ipte_ctrl #(
    parameter int MAX_GROUPS       = 8,
    parameter int DIGITS_PER_GROUP = 4,
    parameter int CW               = $clog2(MAX_GROUPS + 1),
    parameter int DW               = $clog2(DIGITS_PER_GROUP + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                gap_seen,
    input  logic [CW-1:0]       group_count,
    output ipte_pkg::ipte_cmd_t cmd,
    output logic [CW-1:0]       slot,
    output logic [DW-1:0]       pos
);
    import ipte_pkg::*;

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_FINISH  = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    localparam logic [DW-1:0] D_X = DW'(DIGITS_PER_GROUP);

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic [DW-1:0] pos_reg, pos_next;
    logic          valid_reg, valid_next;
    logic          adv;
    logic [CW-1:0] total;
    logic          is_end;

    assign adv    = !valid_reg || m_tready;
    assign total  = gap_seen ? CW'(MAX_GROUPS) : group_count;
    assign is_end = (slot_reg == total - 1'b1) && (pos_reg == D_X);

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        cmd          = '0;
        cmd.accept   = s_tvalid && (state_reg == ST_COLLECT);
        cmd.out_last = is_end;

        unique case (state_reg)
            ST_COLLECT:
            begin
                if (cmd.accept && s_tlast)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.commit = 1'b1;
                slot_next  = '0;
                // The first group has no leading colon.
                pos_next   = DW'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    cmd.load_out = 1'b1;
                    if (pos_reg == D_X)
                    begin
                        if (is_end)
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_COLLECT;
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                            pos_next  = '0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            slot_reg  <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == ST_COLLECT);
    assign m_tvalid = valid_reg;
    assign slot     = slot_reg;
    assign pos      = pos_reg;

endmodule

// ----- hw/rtl/ipv6_text_expander.sv -----
// Order: the group-commit state comes between the final input and the first expanded character.
// Throughput: one input character per cycle while collecting; after the final character
// the input stalls through the group-commit state and the output burst of one character per
// cycle while the receiver keeps up, at most MAX_GROUPS*(DIGITS_PER_GROUP+1)-1 characters.
// Reset: rst_n clears the sequencer, counters, gap flag and partial group; the group
// store is not cleared, and only groups written for the current address are read.
`timescale 1ns / 1ps

module ipv6_text_expander #(
    parameter int MAX_GROUPS       = 8,
    parameter int DIGITS_PER_GROUP = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // end_of_address
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast    // last_char
);
    import ipte_pkg::*;

    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam int DW = $clog2(DIGITS_PER_GROUP + 1);

    ipte_cmd_t     cmd;
    logic          gap_seen;
    logic [CW-1:0] group_count;
    logic [CW-1:0] slot;
    logic [DW-1:0] pos;

    ipte_ctrl #(
        .MAX_GROUPS       (MAX_GROUPS),
        .DIGITS_PER_GROUP (DIGITS_PER_GROUP),
        .CW               (CW),
        .DW               (DW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .gap_seen    (gap_seen),
        .group_count (group_count),
        .cmd         (cmd),
        .slot        (slot),
        .pos         (pos)
    );

    ipte_dp #(
        .MAX_GROUPS       (MAX_GROUPS),
        .DIGITS_PER_GROUP (DIGITS_PER_GROUP),
        .CW               (CW),
        .DW               (DW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .char_in        (s_tdata),
        .slot           (slot),
        .pos            (pos),
        .gap_seen       (gap_seen),
        .group_count    (group_count),
        .char_out       (m_tdata),
        .last_char      (m_tlast)
    );

    // The final input character is followed by a cycle in which no input is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted in the cycle after the final character");

    // The expanded text never ends in a colon.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata != COLON_CHAR)
        else $error("expanded text ends in a colon");

    // Input is never taken while the burst is being produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.load_out))
        else $error("input transaction during output burst");

    // Group count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        group_count <= CW'(MAX_GROUPS))
        else $error("group count beyond store depth");

endmodule

// ----- verif/tb_ipv6_text_expander.sv -----
// Self-checking testbench for the IPv6 text expander: directed and random addresses under random stalls.
`timescale 1ns / 1ps

module tb_ipv6_text_expander;

    import ipte_pkg::*;

    localparam int MAX_GROUPS       = 8;
    localparam int DIGITS_PER_GROUP = 4;
    localparam int RANDOM_CHARS     = 125;
    localparam int PRESSURE_CYCLES  = 150;
    localparam int IDLE_LIMIT       = 3000;
    localparam logic [7:0] COLON    = COLON_CHAR;
    localparam logic [7:0] ZERO     = ZERO_CHAR;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } expanded_char_t;

    // Tracks the address being collected and queues the expanded text it will produce.
    class expansion_scoreboard;
        byte unsigned   store[MAX_GROUPS][DIGITS_PER_GROUP];
        byte unsigned   partial[DIGITS_PER_GROUP];
        int unsigned    digits;
        int unsigned    ngroups;
        int unsigned    gap_at;
        bit             gap_seen;
        bit             after_colon;
        bit             first_group;
        int unsigned    mismatches;
        expanded_char_t expected_chars[$];

        function new();
            mismatches = 0;
            clear_address();
        endfunction

        function void clear_address();
            foreach (partial[k])
                partial[k] = ZERO;
            digits      = 0;
            ngroups     = 0;
            gap_at      = 0;
            gap_seen    = 1'b0;
            after_colon = 1'b0;
        endfunction

        function void append_expected(expanded_char_t e);
            expected_chars.insert(expected_chars.size(), e);
        endfunction

        // Left-pads the current group with zeros; groups past the limit are dropped.
        function void close_group();
            int unsigned pad;
            pad = DIGITS_PER_GROUP - digits;
            if (ngroups < MAX_GROUPS)
            begin
                for (int k = 0; k < DIGITS_PER_GROUP; k++)
                    store[ngroups][k] = (k < pad) ? ZERO : partial[k - pad];
                ngroups++;
            end
            foreach (partial[k])
                partial[k] = ZERO;
            digits = 0;
        endfunction

        function void emit_group(int unsigned g, bit zero_fill);
            expanded_char_t e;
            e.is_last = 1'b0;
            if (!first_group)
            begin
                e.ch = COLON;
                append_expected(e);
            end
            first_group = 1'b0;
            for (int k = 0; k < DIGITS_PER_GROUP; k++)
            begin
                e.ch = zero_fill ? ZERO : store[g][k];
                append_expected(e);
            end
        endfunction

        function void note_char(byte unsigned c, bit is_last);
            if (c == COLON)
            begin
                if (after_colon)
                begin
                    // Second half of a double colon; only the first one places the gap.
                    if (!gap_seen)
                    begin
                        gap_seen = 1'b1;
                        gap_at   = ngroups;
                    end
                    after_colon = 1'b0;
                end
                else
                begin
                    close_group();
                    after_colon = 1'b1;
                end
            end
            else
            begin
                if (digits < DIGITS_PER_GROUP)
                begin
                    partial[digits] = c;
                    digits++;
                end
                after_colon = 1'b0;
            end
            if (!is_last)
                return;

            close_group();
            first_group = 1'b1;
            if (gap_seen)
            begin
                for (int unsigned g = 0; g < gap_at && g < ngroups; g++)
                    emit_group(g, 1'b0);
                for (int unsigned g = 0; g < MAX_GROUPS - ngroups; g++)
                    emit_group(0, 1'b1);
                for (int unsigned g = gap_at; g < ngroups; g++)
                    emit_group(g, 1'b0);
            end
            else
            begin
                for (int unsigned g = 0; g < ngroups; g++)
                    emit_group(g, 1'b0);
            end
            expected_chars[expected_chars.size() - 1].is_last = 1'b1;
            clear_address();
        endfunction

        function void check_char(logic [7:0] ch, logic is_last);
            expanded_char_t e;
            if (expected_chars.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected output: char %h last %b", ch, is_last);
                mismatches++;
                return;
            end
            e = expected_chars.pop_front();
            if (ch !== e.ch || is_last !== e.is_last)
            begin
                if (mismatches < 10)
                    $display("output mismatch: char expected %h got %h, last expected %b got %b",
                             e.ch, ch, e.is_last, is_last);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction
    endclass

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    expansion_scoreboard sb;
    bit          steady         = 1'b0;
    bit          pressure_armed = 1'b0;
    int unsigned chars_sent     = 0;
    int unsigned idle_cycles    = 0;

    ipv6_text_expander #(
        .MAX_GROUPS      (MAX_GROUPS),
        .DIGITS_PER_GROUP(DIGITS_PER_GROUP)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #4 clk = ~clk;

    // Mostly no gap, some short ones, a few long ones, none at all during steady stretches.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic byte unsigned hex_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'h30 + 8'(r);
        if (r < 16)
            return 8'h61 + 8'(r - 10);
        return 8'h41 + 8'(r - 16);
    endfunction

    function automatic void append_char(ref byte unsigned text[$], input byte unsigned c);
        text.insert(text.size(), c);
    endfunction

    function automatic void push_group(ref byte unsigned text[$]);
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        repeat (n)
            append_char(text, hex_digit());
    endfunction

    task automatic send_address(input byte unsigned text[$]);
        int hold;
        for (int i = 0; i < text.size(); i++)
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text[i];
            s_tlast  <= (i == text.size() - 1);
            do
                @(posedge clk);
            while (!s_tready);
            sb.note_char(text[i], i == text.size() - 1);
            chars_sent++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_char(m_tdata, m_tlast);
    end

    // Receiver: random stalls, plus one long hold-off that makes the block back up its input.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (pressure_armed && m_tvalid)
            begin
                pressure_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
            end
            else if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        byte unsigned text[$];
        int unsigned  random_start;
        int           n;
        int           before_gap;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Triple colon: a gap followed by an empty group.
        text = '{COLON, COLON, COLON};
        send_address(text);
        // Extreme byte value, mixed case, and a second double colon that is ignored.
        text = '{8'hFF, COLON, COLON, "a", COLON, COLON, "F"};
        send_address(text);
        // Zero byte as a digit and one digit too many.
        text = '{8'h00, "1", "2", "3", "4"};
        send_address(text);
        // Eight groups then a double colon: no zero groups, trailing group dropped.
        text = '{"1", COLON, "2", COLON, "3", COLON, "4", COLON, "5", COLON,
                 "6", COLON, "7", COLON, "8", COLON, COLON};
        send_address(text);

        pressure_armed = 1'b1;
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            text.delete();
            if ($urandom_range(0, 99) < 70)
            begin
                if ($urandom_range(0, 1))
                begin
                    n = $urandom_range(0, 7);
                    before_gap = $urandom_range(0, n);
                    for (int i = 0; i < before_gap; i++)
                    begin
                        if (i > 0)
                            append_char(text, COLON);
                        push_group(text);
                    end
                    append_char(text, COLON);
                    append_char(text, COLON);
                    for (int i = 0; i < n - before_gap; i++)
                    begin
                        if (i > 0)
                            append_char(text, COLON);
                        push_group(text);
                    end
                end
                else
                begin
                    // Mostly full addresses, sometimes short or with extra groups.
                    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : MAX_GROUPS;
                    for (int i = 0; i < n; i++)
                    begin
                        if (i > 0)
                            append_char(text, COLON);
                        push_group(text);
                    end
                end
            end
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    append_char(text, ($urandom_range(0, 9) < 4) ? COLON
                                                                  : 8'($urandom_range(0, 255)));
            end
            send_address(text);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
